// ===== rtl/crf_pkg.sv =====
// ----------------------------------------------------------------------------
// crf_pkg
// Shared types and constants of the chunk reorder frame ring: the field
// layout of the input and result items, command and opcode codes, and the
// entry type of the queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

package crf_pkg;

  // Ring geometry.
  localparam int BUFFER_COUNT = 3;
  localparam int CHUNK_COUNT  = 5;

  // Field widths of the item formats.
  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 3;
  localparam int FRAME_W  = 16;
  localparam int CMD_W    = 2;

  // Internal widths that follow from the ring geometry.
  localparam int SLOT_W = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
  localparam int CHK_W  = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
  localparam int HC_W   = $clog2(CHUNK_COUNT + 1);

  localparam logic [CHUNK_COUNT-1:0] FULL_MASK = {CHUNK_COUNT{1'b1}};

  localparam logic [FRAME_W-1:0] TOTAL_FRAMES_RESET = 16'd10;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input opcodes.
  localparam logic [OPCODE_W-1:0] OP_START     = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_PROCESSED = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DISPLAYED = 2'd2;

  // Result commands.
  localparam logic [CMD_W-1:0] CMD_DISPATCH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FRAME_DONE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FINISHED   = 2'd3;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [INDEX_W-1:0]  buffer_index;
    logic [INDEX_W-1:0]  chunk_index;
  } in_item_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [FRAME_W-1:0] frame_number;
    logic [INDEX_W-1:0] slot;
    logic [INDEX_W-1:0] part;
    logic               last;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_PROC,
    KIND_DISP
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [SLOT_W-1:0] buf_idx;
    logic [CHK_W-1:0]  chunk_idx;
  } q_entry_t;

endpackage

`default_nettype wire

// ===== rtl/chunk_reorder_frame_ring.sv =====
// ----------------------------------------------------------------------------
// chunk_reorder_frame_ring
// In-order commit controller for chunked frames over a ring of frame buffers.
// ----------------------------------------------------------------------------
// An accepted item enters a two-entry queue at once, so the input keeps taking
// items while results are still being delivered, as long as the queue has room.
// The sequencer takes an item from the queue in its idle state; a start then
// issues its dispatch commands directly, while an in-range chunk event after
// the start first passes through an evaluation state. Results leave one per
// cycle while the output register is being emptied; a result that waits in
// the output register stalls the sequencer. A chunk event can retire a frame,
// redispatch the buffer and release a whole frame of writes. A repeated start
// or an item that arrives before the start or after the finish has no result.
// Items with an opcode of three, or chunk items with an out-of-range index,
// never reach the queue. Writes to total_frames are registered and apply also
// to an item that is already being processed.
`default_nettype none

module chunk_reorder_frame_ring import crf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_item_t           in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_item_t               out_item_o,
  input  wire logic               cfg_we_i,
  input  wire logic [FRAME_W-1:0] cfg_wdata_i
);

  logic     push;
  q_entry_t push_data;
  logic     q_full;
  logic     q_valid;
  q_entry_t q_data;
  logic     q_pop;

  crf_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  crf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  crf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== rtl/crf_front.sv =====
// ----------------------------------------------------------------------------
// crf_front
// Accepts input items while the queue has room, drops the ones that can
// never have an effect and turns the rest into compact queue entries.
// ----------------------------------------------------------------------------
`default_nettype none

module crf_front import crf_pkg::*; (
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  input  wire logic     q_full_i,
  output logic          push_o,
  output q_entry_t      push_data_o
);

  logic     in_range;
  logic     keep;
  q_entry_t entry;

  // Indices are compared one bit wider so that a full eight-entry ring works.
  assign in_range = ({1'b0, in_item_i.buffer_index} < (INDEX_W + 1)'(BUFFER_COUNT)) &&
                    ({1'b0, in_item_i.chunk_index} < (INDEX_W + 1)'(CHUNK_COUNT));

  always_comb begin
    entry.buf_idx   = in_item_i.buffer_index[SLOT_W-1:0];
    entry.chunk_idx = in_item_i.chunk_index[CHK_W-1:0];
    entry.kind      = KIND_START;
    keep            = 1'b0;
    case (in_item_i.opcode)
      OP_START: begin
        entry.kind = KIND_START;
        keep       = 1'b1;
      end
      OP_PROCESSED: begin
        entry.kind = KIND_PROC;
        keep       = in_range;
      end
      OP_DISPLAYED: begin
        entry.kind = KIND_DISP;
        keep       = in_range;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready_o  = !q_full_i;
  assign push_o      = in_valid_i && !q_full_i && keep;
  assign push_data_o = entry;

endmodule

`default_nettype wire

// ===== rtl/crf_queue.sv =====
// ----------------------------------------------------------------------------
// crf_queue
// Short first-in first-out queue of classified items between the front
// and the back of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module crf_queue import crf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire q_entry_t push_data_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output q_entry_t      data_o
);

  q_entry_t          store_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds its depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && full_o && !pop_i) |=> (count_q == QCNT_W'(QUEUE_DEPTH)))
    else $error("push into a full queue changed the count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with misaligned pointers");

endmodule

`default_nettype wire

// ===== rtl/crf_back.sv =====
// ----------------------------------------------------------------------------
// crf_back
// Commit sequencer: keeps the processed and displayed masks of every buffer
// and the head frame, and emits the resulting commands into an output
// register, one per cycle while that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module crf_back import crf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [FRAME_W-1:0] cfg_wdata_i,
  input  wire logic               q_valid_i,
  input  wire q_entry_t           q_data_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_item_t               out_item_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DISPATCH,
    S_DONE,
    S_FINISH,
    S_WRITES
  } state_e;

  state_e                 state_q;
  logic [FRAME_W-1:0]     total_frames_q;
  logic [CHUNK_COUNT-1:0] proc_q [BUFFER_COUNT];
  logic [CHUNK_COUNT-1:0] disp_q [BUFFER_COUNT];
  logic [FRAME_W-1:0]     head_frame_q;
  logic [SLOT_W-1:0]      head_slot_q;
  logic [HC_W-1:0]        head_chunk_q;
  logic                   started_q;
  logic                   finished_q;
  kind_e                  cur_kind_q;
  logic [FRAME_W-1:0]     d_frame_q;
  logic [SLOT_W-1:0]      d_slot_q;
  logic [CHK_W-1:0]       d_part_q;
  logic                   d_start_q;
  logic                   out_valid_q;
  out_item_t              out_q;

  logic                   out_free;
  logic                   emit;
  logic [CHUNK_COUNT-1:0] proc_head;
  logic [CHUNK_COUNT-1:0] disp_head;
  logic [CHUNK_COUNT-1:0] head_vec;
  logic [CHUNK_COUNT-1:0] next_vec;
  logic [HC_W-1:0]        next_chunk;
  logic                   write_pend;
  logic                   write_more;
  logic [SLOT_W-1:0]      next_slot;
  logic                   redispatch;
  logic                   finish_after;
  logic                   write_after_done;
  logic [FRAME_W:0]       d_frame_inc;
  logic                   more_frames;
  logic                   d_last_part;

  assign out_free  = !out_valid_q || out_ready_i;
  assign proc_head = proc_q[head_slot_q];
  assign disp_head = disp_q[head_slot_q];

  // Every emitting state loads the output register as soon as it is free.
  assign emit = out_free && ((state_q == S_DONE) || (state_q == S_DISPATCH) ||
                             (state_q == S_FINISH) || (state_q == S_WRITES));

  // Next write is possible when the head chunk has been processed.
  assign head_vec   = proc_head >> head_chunk_q;
  assign write_pend = !finished_q && (head_chunk_q < HC_W'(CHUNK_COUNT)) && head_vec[0];
  assign next_chunk = head_chunk_q + 1'b1;
  assign next_vec   = proc_head >> next_chunk;
  assign write_more = (next_chunk < HC_W'(CHUNK_COUNT)) && next_vec[0];

  assign next_slot = (head_slot_q == SLOT_W'(BUFFER_COUNT - 1)) ? '0 : head_slot_q + 1'b1;

  assign redispatch   = ({1'b0, head_frame_q} + (FRAME_W + 1)'(BUFFER_COUNT)) <
                        {1'b0, total_frames_q};
  assign finish_after = ({1'b0, head_frame_q} + 1'b1) >= {1'b0, total_frames_q};
  assign write_after_done = proc_q[next_slot][0];

  // At start one buffer after another is dispatched while frames remain.
  assign d_frame_inc = {1'b0, d_frame_q} + 1'b1;
  assign more_frames = d_start_q &&
                       (d_frame_inc < (FRAME_W + 1)'(BUFFER_COUNT)) &&
                       (d_frame_inc < {1'b0, total_frames_q});
  assign d_last_part = (d_part_q == CHK_W'(CHUNK_COUNT - 1));

  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      total_frames_q <= TOTAL_FRAMES_RESET;
      for (int i = 0; i < BUFFER_COUNT; i++) begin
        proc_q[i] <= '0;
        disp_q[i] <= '0;
      end
      head_frame_q <= '0;
      head_slot_q  <= '0;
      head_chunk_q <= '0;
      started_q    <= 1'b0;
      finished_q   <= 1'b0;
      cur_kind_q   <= KIND_START;
      d_frame_q    <= '0;
      d_slot_q     <= '0;
      d_part_q     <= '0;
      d_start_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        total_frames_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (q_valid_i && !finished_q) begin
            cur_kind_q <= q_data_i.kind;
            if (q_data_i.kind == KIND_START) begin
              if (!started_q) begin
                started_q <= 1'b1;
                d_frame_q <= '0;
                d_slot_q  <= '0;
                d_part_q  <= '0;
                d_start_q <= 1'b1;
                state_q   <= (head_frame_q >= total_frames_q) ? S_FINISH : S_DISPATCH;
              end
            end else if (started_q) begin
              if (q_data_i.kind == KIND_PROC) begin
                proc_q[q_data_i.buf_idx][q_data_i.chunk_idx] <= 1'b1;
              end else begin
                disp_q[q_data_i.buf_idx][q_data_i.chunk_idx] <= 1'b1;
              end
              state_q <= S_EVAL;
            end
          end
        end

        S_EVAL: begin
          if (cur_kind_q == KIND_DISP && disp_head == FULL_MASK) begin
            state_q <= S_DONE;
          end else if (write_pend) begin
            state_q <= S_WRITES;
          end else begin
            state_q <= S_IDLE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_q <= '{command: CMD_FRAME_DONE, frame_number: head_frame_q,
                       slot: INDEX_W'(head_slot_q), part: '0,
                       last: !redispatch && !finish_after && !write_after_done};
            proc_q[head_slot_q] <= '0;
            disp_q[head_slot_q] <= '0;
            head_frame_q <= head_frame_q + 1'b1;
            head_slot_q  <= next_slot;
            head_chunk_q <= '0;
            if (redispatch) begin
              d_frame_q <= head_frame_q + FRAME_W'(BUFFER_COUNT);
              d_slot_q  <= head_slot_q;
              d_part_q  <= '0;
              d_start_q <= 1'b0;
              state_q   <= S_DISPATCH;
            end else if (finish_after) begin
              state_q <= S_FINISH;
            end else if (write_after_done) begin
              state_q <= S_WRITES;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end

        S_DISPATCH: begin
          if (out_free) begin
            out_q <= '{command: CMD_DISPATCH, frame_number: d_frame_q,
                       slot: INDEX_W'(d_slot_q), part: INDEX_W'(d_part_q),
                       last: d_last_part && !more_frames && (d_start_q || !write_pend)};
            if (!d_last_part) begin
              d_part_q <= d_part_q + 1'b1;
            end else if (more_frames) begin
              d_frame_q <= d_frame_q + 1'b1;
              d_slot_q  <= d_slot_q + 1'b1;
              d_part_q  <= '0;
            end else if (!d_start_q && write_pend) begin
              state_q <= S_WRITES;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end

        S_FINISH: begin
          if (out_free) begin
            out_q <= '{command: CMD_FINISHED, frame_number: head_frame_q,
                       slot: '0, part: '0, last: 1'b1};
            finished_q <= 1'b1;
            state_q    <= S_IDLE;
          end
        end

        S_WRITES: begin
          if (out_free) begin
            out_q <= '{command: CMD_WRITE, frame_number: head_frame_q,
                       slot: INDEX_W'(head_slot_q), part: INDEX_W'(head_chunk_q),
                       last: !write_more};
            head_chunk_q <= next_chunk;
            if (!write_more) begin
              state_q <= S_IDLE;
            end
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> started_q)
    else $error("finished without a start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_chunk_q <= HC_W'(CHUNK_COUNT)) && (head_slot_q < SLOT_W'(BUFFER_COUNT)))
    else $error("head chunk or head slot out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.command == CMD_FINISHED) |-> out_q.last)
    else $error("finished command not marked last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finished_q && state_q == S_IDLE) |=> (state_q == S_IDLE))
    else $error("sequencer left idle after finishing");

endmodule

`default_nettype wire

// ===== sim/chunk_reorder_frame_ring_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_reorder_frame_ring_tb
// Drives start, chunk-processed and chunk-displayed items into the frame ring
// controller and checks every command that comes out against an in-order
// commit model kept in a small scoreboard. Covers the ignored cases, in-order
// write release, redispatch near the end, a late register change and the
// finish, under several idle and backpressure patterns.
// ----------------------------------------------------------------------------

import crf_pkg::*;

class commit_scoreboard;
  localparam int MAX_CMDS_PER_EVENT = 24;
  localparam int MAX_REPORTS        = 10;

  logic [FRAME_W-1:0]     total_frames;
  logic [CHUNK_COUNT-1:0] proc_mask [BUFFER_COUNT];
  logic [CHUNK_COUNT-1:0] shown_mask [BUFFER_COUNT];
  int unsigned            head_frame;
  int unsigned            head_chunk;
  bit                     started;
  bit                     finished;
  out_item_t              batch[$];
  out_item_t              due_cmds[$];
  int unsigned            mismatches;
  int unsigned            events_noted;
  int unsigned            quiet_events;
  int unsigned            cmd_seen [4];

  function new();
    total_frames = TOTAL_FRAMES_RESET;
    for (int i = 0; i < BUFFER_COUNT; i++) begin
      proc_mask[i]  = '0;
      shown_mask[i] = '0;
    end
    head_frame   = 0;
    head_chunk   = 0;
    started      = 1'b0;
    finished     = 1'b0;
    mismatches   = 0;
    events_noted = 0;
    quiet_events = 0;
    for (int i = 0; i < 4; i++) cmd_seen[i] = 0;
  endfunction

  function void add_cmd(logic [CMD_W-1:0] cmd, int unsigned frame, int unsigned slot,
                        int unsigned part);
    out_item_t c;
    c.command      = cmd;
    c.frame_number = FRAME_W'(frame);
    c.slot         = INDEX_W'(slot);
    c.part         = INDEX_W'(part);
    c.last         = 1'b0;
    if (batch.size() < MAX_CMDS_PER_EVENT) batch.push_back(c);
  endfunction

  function void dispatch_frame(int unsigned frame, int unsigned slot);
    for (int unsigned j = 0; j < CHUNK_COUNT; j++) add_cmd(CMD_DISPATCH, frame, slot, j);
  endfunction

  // Releases the head frame's chunks to the display as long as they are
  // contiguous from the current write position.
  function void release_writes();
    int unsigned slot;
    slot = head_frame % BUFFER_COUNT;
    while (head_chunk < CHUNK_COUNT && proc_mask[slot][head_chunk]) begin
      add_cmd(CMD_WRITE, head_frame, slot, head_chunk);
      head_chunk++;
    end
  endfunction

  function void note_event(in_item_t ev);
    int unsigned buf_i;
    int unsigned chk;
    int unsigned slot;
    batch.delete();
    events_noted++;
    buf_i = ev.buffer_index;
    chk   = ev.chunk_index;
    if (!finished) begin
      if (ev.opcode == OP_START) begin
        if (!started) begin
          started = 1'b1;
          for (int unsigned i = 0; i < BUFFER_COUNT && i < total_frames; i++)
            dispatch_frame(i, i);
          if (head_frame >= total_frames) begin
            add_cmd(CMD_FINISHED, head_frame, 0, 0);
            finished = 1'b1;
          end
        end
      end else if (ev.opcode == OP_PROCESSED || ev.opcode == OP_DISPLAYED) begin
        if (started && buf_i < BUFFER_COUNT && chk < CHUNK_COUNT) begin
          if (ev.opcode == OP_PROCESSED) begin
            proc_mask[buf_i][chk] = 1'b1;
          end else begin
            slot = head_frame % BUFFER_COUNT;
            shown_mask[buf_i][chk] = 1'b1;
            // Only a displayed item can retire the head frame.
            if (shown_mask[slot] == FULL_MASK) begin
              add_cmd(CMD_FRAME_DONE, head_frame, slot, 0);
              proc_mask[slot]  = '0;
              shown_mask[slot] = '0;
              if (head_frame + BUFFER_COUNT < total_frames)
                dispatch_frame(head_frame + BUFFER_COUNT, slot);
              head_frame++;
              head_chunk = 0;
              if (head_frame >= total_frames) begin
                add_cmd(CMD_FINISHED, head_frame, 0, 0);
                finished = 1'b1;
              end
            end
          end
          if (!finished) release_writes();
        end
      end
    end
    if (batch.size() == 0) begin
      quiet_events++;
    end else begin
      batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) due_cmds.push_back(batch[i]);
    end
  endfunction

  function void check_command(out_item_t got);
    out_item_t want;
    if (due_cmds.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("ERROR: unexpected command cmd=%0d frame=%0d slot=%0d part=%0d last=%0b",
                 got.command, got.frame_number, got.slot, got.part, got.last);
      return;
    end
    want = due_cmds.pop_front();
    cmd_seen[want.command]++;
    if (got.command !== want.command || got.frame_number !== want.frame_number ||
        got.slot !== want.slot || got.part !== want.part || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("ERROR: expected cmd=%0d frame=%0d slot=%0d part=%0d last=%0b",
                 want.command, want.frame_number, want.slot, want.part, want.last);
        $display("       actual   cmd=%0d frame=%0d slot=%0d part=%0d last=%0b",
                 got.command, got.frame_number, got.slot, got.part, got.last);
      end
    end
  endfunction

  function int unsigned failures();
    return mismatches + due_cmds.size();
  endfunction
endclass

module chunk_reorder_frame_ring_tb;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_item_t           in_item_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_item_t          out_item_o;
  logic               cfg_we_i    = 1'b0;
  logic [FRAME_W-1:0] cfg_wdata_i = '0;
  logic               hold_req    = 1'b0;

  int unsigned        snd_idle_pct;
  int unsigned        rcv_idle_pct;
  commit_scoreboard   sb;

  chunk_reorder_frame_ring dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Display side: random backpressure, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) sb.check_command(out_item_o);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("ERROR: nothing accepted for %0d cycles", STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(input in_item_t it);
    int unsigned n_idle;
    n_idle = 0;
    while ($urandom_range(99) < snd_idle_pct) n_idle++;
    if (n_idle > 0) begin
      in_valid_i <= 1'b0;
      repeat (n_idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_event(it);
  endtask

  task automatic send_event(input logic [OPCODE_W-1:0] op, input int unsigned b,
                            input int unsigned c);
    in_item_t it;
    it.opcode       = op;
    it.buffer_index = INDEX_W'(b);
    it.chunk_index  = INDEX_W'(c);
    send_item(it);
  endtask

  // Drops valid, waits for every expected command, then lets any ignored
  // items still inside the block drain out.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.due_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_total(input logic [FRAME_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.total_frames = value;
  endtask

  task automatic send_noise();
    case ($urandom_range(5))
      0: send_event(OP_PROCESSED, $urandom_range(7, BUFFER_COUNT), $urandom_range(7));
      1: send_event(OP_DISPLAYED, $urandom_range(BUFFER_COUNT - 1),
                    $urandom_range(7, CHUNK_COUNT));
      2: send_event(OP_UNUSED, $urandom_range(7), $urandom_range(7));
      3: send_event(OP_START, $urandom_range(7), $urandom_range(7));
      4: send_event(OP_PROCESSED, $urandom_range(BUFFER_COUNT - 1),
                    $urandom_range(CHUNK_COUNT - 1));
      default: send_event(OP_DISPLAYED, $urandom_range(BUFFER_COUNT - 1),
                          $urandom_range(CHUNK_COUNT - 1));
    endcase
  endtask

  // Each frame's chunks are processed in random order, and each chunk is
  // displayed some time after it was processed, with stray items mixed in.
  task automatic run_frames(input int unsigned first, input int unsigned last_frame);
    logic [CHUNK_COUNT-1:0] p_sent;
    logic [CHUNK_COUNT-1:0] d_sent;
    int unsigned            slot;
    int unsigned            pick;
    int unsigned            cand[$];
    for (int unsigned f = first; f <= last_frame; f++) begin
      slot   = f % BUFFER_COUNT;
      p_sent = '0;
      d_sent = '0;
      while (d_sent != FULL_MASK) begin
        if ($urandom_range(99) < 15) begin
          send_noise();
        end else begin
          cand.delete();
          for (int unsigned c = 0; c < CHUNK_COUNT; c++) begin
            if (!p_sent[c]) cand.push_back(c);
            else if (!d_sent[c]) cand.push_back(CHUNK_COUNT + c);
          end
          pick = cand[$urandom_range(cand.size() - 1)];
          if (pick < CHUNK_COUNT) begin
            send_event(OP_PROCESSED, slot, pick);
            p_sent[pick] = 1'b1;
          end else begin
            send_event(OP_DISPLAYED, slot, pick - CHUNK_COUNT);
            d_sent[pick - CHUNK_COUNT] = 1'b1;
          end
        end
      end
    end
  endtask

  task automatic run_directed();
    // Chunk items and an unused opcode before the start are ignored.
    send_event(OP_PROCESSED, 0, 0);
    send_event(OP_DISPLAYED, 2, 4);
    send_event(OP_UNUSED, 7, 7);
    send_event(OP_START, 0, 0);
    send_event(OP_START, 7, 7);
    // Indices outside the ring or the frame.
    send_event(OP_PROCESSED, 3, 0);
    send_event(OP_PROCESSED, 7, 4);
    send_event(OP_DISPLAYED, 0, 5);
    send_event(OP_PROCESSED, 2, 7);
    send_event(OP_UNUSED, 0, 0);
    // Chunk 1 is held back until chunk 0 arrives.
    send_event(OP_PROCESSED, 0, 1);
    send_event(OP_PROCESSED, 0, 0);
    send_event(OP_PROCESSED, 1, 4);
    send_event(OP_DISPLAYED, 0, 0);
    send_event(OP_PROCESSED, 0, 4);
    send_event(OP_PROCESSED, 0, 2);
    send_event(OP_PROCESSED, 0, 3);
    send_event(OP_DISPLAYED, 1, 4);
    send_event(OP_DISPLAYED, 0, 3);
    send_event(OP_DISPLAYED, 0, 1);
    send_event(OP_DISPLAYED, 0, 2);
    send_event(OP_DISPLAYED, 0, 4);
  endtask

  initial begin
    sb = new();
    snd_idle_pct = 35;
    rcv_idle_pct = 74;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_total(16'hFFFF);
    run_directed();
    run_frames(1, 10);
    settle();

    snd_idle_pct = 74;
    rcv_idle_pct = 35;
    write_total(16'd45);
    hold_req <= 1'b1;
    run_frames(11, 17);
    settle();

    // Near the end no frame is left to redispatch.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_total(16'd21);
    run_frames(18, 19);
    settle();

    // The total drops below the head frame, so the next retired frame finishes.
    write_total(16'd1);
    run_frames(20, 20);
    repeat (12) send_event(OPCODE_W'($urandom_range(3)), $urandom_range(7), $urandom_range(7));
    settle();

    $display("Run covered %0d items (%0d without commands); head frame reached %0d.",
             sb.events_noted, sb.quiet_events, sb.head_frame);
    $display("Checked %0d dispatch, %0d write, %0d frame done, %0d finished; %0d bad, %0d missing.",
             sb.cmd_seen[CMD_DISPATCH], sb.cmd_seen[CMD_WRITE], sb.cmd_seen[CMD_FRAME_DONE],
             sb.cmd_seen[CMD_FINISHED], sb.mismatches, sb.due_cmds.size());
    if (sb.failures() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
